>>> rtl/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// shared widths, codes and control types of the sorted rank list
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int KEY_W    = 32;
  localparam int RANK_W   = 6;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_RANK = 2'd2;

  localparam logic signed [RANK_W-1:0] RANK_NONE = -6'sd1;

  // cell operations
  localparam logic [1:0] CELL_HOLD       = 2'd0;
  localparam logic [1:0] CELL_FROM_LEFT  = 2'd1;
  localparam logic [1:0] CELL_FROM_RIGHT = 2'd2;
  localparam logic [1:0] CELL_LOAD       = 2'd3;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

  // what the row shows back to the sequencer
  typedef struct packed {
    logic [CAPACITY-1:0]           gt;
    logic [CAPACITY-1:0]           lt;
    logic [CAPACITY-1:0]           hit;
    logic [CAPACITY-1:0][ID_W-1:0] ids;
  } row_view_t;

endpackage

>>> rtl/srl_if.sv
// ----------------------------------------------------------------------------
// srl_if
// request and result channels of the sorted rank list
// ----------------------------------------------------------------------------
interface srl_in_if;
  import srl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [ID_W-1:0]          entry_id;
  logic [KEY_W-1:0]         key;
  logic signed [RANK_W-1:0] known_rank;

  modport source (output valid, cmd, entry_id, key, known_rank, input ready);
  modport sink   (input valid, cmd, entry_id, key, known_rank, output ready);
endinterface

interface srl_out_if;
  import srl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [ID_W-1:0]          moved_id;
  logic signed [RANK_W-1:0] new_rank;
  logic                     last;

  modport source (output valid, status, moved_id, new_rank, last, input ready);
  modport sink   (input valid, status, moved_id, new_rank, last, output ready);
endinterface

>>> rtl/srl_cell.sv
// ----------------------------------------------------------------------------
// srl_cell
// one slot of the sorted row: holds an (id, key) pair and compares it
// ----------------------------------------------------------------------------
module srl_cell (
  input  logic                      clk,
  input  logic [srl_pkg::IDX_W-1:0] my_idx,
  input  srl_pkg::cell_ctrl_t       ctl,
  input  logic [srl_pkg::ID_W-1:0]  left_id,
  input  logic [srl_pkg::KEY_W-1:0] left_key,
  input  logic [srl_pkg::ID_W-1:0]  next_slot_id,
  input  logic [srl_pkg::KEY_W-1:0] right_key,
  output logic [srl_pkg::ID_W-1:0]  id,
  output logic [srl_pkg::KEY_W-1:0] key,
  output logic                      gt,
  output logic                      lt,
  output logic                      hit
);
  import srl_pkg::*;

  logic [ID_W-1:0]  id_r, id_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  always_comb begin
    id_nxt  = id_r;
    key_nxt = key_r;
    if (ctl.idx == my_idx) begin
      case (ctl.op)
        CELL_FROM_LEFT: begin
          id_nxt  = left_id;
          key_nxt = left_key;
        end
        CELL_FROM_RIGHT: begin
          id_nxt  = next_slot_id;
          key_nxt = right_key;
        end
        CELL_LOAD: begin
          id_nxt  = ctl.id;
          key_nxt = ctl.key;
        end
        default: begin
          id_nxt  = id_r;
          key_nxt = key_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    key_r <= key_nxt;
  end

  // subject key against this slot
  assign gt  = ctl.key > key_r;
  assign lt  = ctl.key < key_r;
  assign hit = ctl.id == id_r;
  assign id  = id_r;
  assign key = key_r;

endmodule

>>> rtl/srl_ctrl.sv
// ----------------------------------------------------------------------------
// srl_ctrl
// sequencer: plans each command, steps the row one shift per beat
// ----------------------------------------------------------------------------
module srl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  srl_in_if.sink             in_bus,
  srl_out_if.source          out_bus,
  input  srl_pkg::row_view_t view,
  output srl_pkg::cell_ctrl_t ctl
);
  import srl_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PLAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  rank_r, rank_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic              dn_r, dn_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic                     ov_r, ov_nxt;
  logic [STAT_W-1:0]        ost_r, ost_nxt;
  logic [ID_W-1:0]          oid_r, oid_nxt;
  logic signed [RANK_W-1:0] ork_r, ork_nxt;
  logic                     olast_r, olast_nxt;

  logic             out_free;
  logic [CNT_W-1:0] add_pos, up_t, dn_t, src;
  logic             rank_ok;

  assign out_free = !ov_r || out_bus.ready;
  assign src      = dn_r ? cur_r + CNT_W'(1) : cur_r - CNT_W'(1);

  // placement searches over the row flags
  always_comb begin
    add_pos = fill_r;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (CNT_W'(i) < fill_r && view.gt[i]) add_pos = CNT_W'(i);
    end
    up_t = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) < rank_r && !view.gt[i]) up_t = CNT_W'(i + 1);
    end
    dn_t = fill_r - CNT_W'(1);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (CNT_W'(i) > rank_r && CNT_W'(i) < fill_r && !view.lt[i]) dn_t = CNT_W'(i - 1);
    end
  end

  assign rank_ok = !neg_r && (rank_r < fill_r) && view.hit[rank_r[IDX_W-1:0]];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    id_nxt    = id_r;
    key_nxt   = key_r;
    neg_nxt   = neg_r;
    rank_nxt  = rank_r;
    fill_nxt  = fill_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    dn_nxt    = dn_r;
    stat_nxt  = stat_r;
    ov_nxt    = ov_r && !out_bus.ready;
    ost_nxt   = ost_r;
    oid_nxt   = oid_r;
    ork_nxt   = ork_r;
    olast_nxt = olast_r;
    ctl.op    = CELL_HOLD;
    ctl.idx   = cur_r[IDX_W-1:0];
    ctl.id    = id_r;
    ctl.key   = key_r;

    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          cmd_nxt  = in_bus.cmd;
          id_nxt   = in_bus.entry_id;
          key_nxt  = in_bus.key;
          neg_nxt  = in_bus.known_rank[RANK_W-1];
          rank_nxt = CNT_W'(in_bus.known_rank[RANK_W-2:0]);
          if (in_bus.cmd != CMD_NONE) state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        stat_nxt  = ST_OK;
        state_nxt = S_FINAL;
        case (cmd_r)
          CMD_ADD: begin
            if (fill_r >= CNT_W'(CAPACITY)) begin
              stat_nxt = ST_FULL;
            end else begin
              end_nxt = add_pos;
              cur_nxt = fill_r;
              dn_nxt  = 1'b0;
              if (add_pos != fill_r) state_nxt = S_SHIFT;
            end
          end
          CMD_MOVE: begin
            if (!rank_ok) begin
              stat_nxt = ST_BAD_RANK;
            end else begin
              cur_nxt = rank_r;
              if (up_t < rank_r) begin
                end_nxt   = up_t;
                dn_nxt    = 1'b0;
                state_nxt = S_SHIFT;
              end else if (dn_t > rank_r) begin
                end_nxt   = dn_t;
                dn_nxt    = 1'b1;
                state_nxt = S_SHIFT;
              end else begin
                end_nxt = rank_r;
              end
            end
          end
          CMD_REMOVE: begin
            if (!rank_ok) begin
              stat_nxt = ST_BAD_RANK;
            end else begin
              cur_nxt = rank_r;
              end_nxt = fill_r - CNT_W'(1);
              dn_nxt  = 1'b1;
              if (rank_r != fill_r - CNT_W'(1)) state_nxt = S_SHIFT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SHIFT: begin
        if (out_free) begin
          ctl.op    = dn_r ? CELL_FROM_RIGHT : CELL_FROM_LEFT;
          ov_nxt    = 1'b1;
          ost_nxt   = ST_OK;
          oid_nxt   = view.ids[src[IDX_W-1:0]];
          ork_nxt   = $signed(RANK_W'(cur_r));
          olast_nxt = 1'b0;
          cur_nxt   = dn_r ? cur_r + CNT_W'(1) : cur_r - CNT_W'(1);
          if (cur_nxt == end_r) state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = stat_r;
          oid_nxt   = id_r;
          ork_nxt   = RANK_NONE;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (stat_r == ST_OK) begin
            ctl.idx = end_r[IDX_W-1:0];
            if (cmd_r == CMD_REMOVE) begin
              fill_nxt = fill_r - CNT_W'(1);
            end else begin
              ctl.op  = CELL_LOAD;
              ork_nxt = $signed(RANK_W'(end_r));
              if (cmd_r == CMD_ADD) fill_nxt = fill_r + CNT_W'(1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    id_r    <= id_nxt;
    key_r   <= key_nxt;
    neg_r   <= neg_nxt;
    rank_r  <= rank_nxt;
    cur_r   <= cur_nxt;
    end_r   <= end_nxt;
    dn_r    <= dn_nxt;
    stat_r  <= stat_nxt;
    ost_r   <= ost_nxt;
    oid_r   <= oid_nxt;
    ork_r   <= ork_nxt;
    olast_r <= olast_nxt;
  end

  assign in_bus.ready     = state_r == S_IDLE;
  assign out_bus.valid    = ov_r;
  assign out_bus.status   = ost_r;
  assign out_bus.moved_id = oid_r;
  assign out_bus.new_rank = ork_r;
  assign out_bus.last     = olast_r;

endmodule

>>> rtl/sorted_rank_list_top.sv
// ----------------------------------------------------------------------------
// sorted_rank_list_top
// table of up to 32 (id, key) entries kept in descending key order
// ----------------------------------------------------------------------------
// usage
//   in_bus carries one command per beat: add, move with a new key, or remove;
//   move and remove name the rank the entry last held. command code three is
//   dropped with no result.
//   out_bus returns one beat per entry whose rank changed, in shift order,
//   then a beat for the subject entry with last set; remove reports the
//   subject at rank -1. a full table or a bad rank gives a single error beat.
// timing
//   a plan state follows the command beat, then one result beat per cycle
//   while the receiver keeps up. the row moves one slot per cycle unless
//   the output register is stalled, so the shift count sets the rate.
// reset
//   rst_n (synchronous) empties the table; slot contents are not cleared,
//   only slots below the fill count are ever looked at.
// stalls
//   results sit in an output register; while its beat waits on out_bus.ready,
//   the row holds still; in_bus.ready stays low till the last beat is queued.
// ----------------------------------------------------------------------------
module sorted_rank_list_top (
  input  logic      clk,
  input  logic      rst_n,
  srl_in_if.sink    in_bus,
  srl_out_if.source out_bus
);
  import srl_pkg::*;

  // row of slots, each wired to its two neighbors
  logic [CAPACITY-1:0][ID_W-1:0]  cell_ids;
  logic [CAPACITY-1:0][KEY_W-1:0] cell_keys;
  logic [CAPACITY-1:0]            cell_gt;
  logic [CAPACITY-1:0]            cell_lt;
  logic [CAPACITY-1:0]            cell_hit;

  cell_ctrl_t ctl;
  row_view_t  view;

  // flags and ids go back to the sequencer as one bundle
  assign view.gt  = cell_gt;
  assign view.lt  = cell_lt;
  assign view.hit = cell_hit;
  assign view.ids = cell_ids;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_W-1:0]  l_id, r_id;
    logic [KEY_W-1:0] l_key, r_key;

    // the ends of the row see zero neighbors, never selected in practice
    if (g == 0) begin : g_first
      assign l_id  = '0;
      assign l_key = '0;
    end else begin : g_mid_l
      assign l_id  = cell_ids[g-1];
      assign l_key = cell_keys[g-1];
    end

    if (g == CAPACITY - 1) begin : g_lastc
      assign r_id  = '0;
      assign r_key = '0;
    end else begin : g_mid_r
      assign r_id  = cell_ids[g+1];
      assign r_key = cell_keys[g+1];
    end

    srl_cell u_cell (
      .clk          (clk),
      .my_idx       (IDX_W'(g)),
      .ctl          (ctl),
      .left_id      (l_id),
      .left_key     (l_key),
      .next_slot_id (r_id),
      .right_key    (r_key),
      .id           (cell_ids[g]),
      .key          (cell_keys[g]),
      .gt           (cell_gt[g]),
      .lt           (cell_lt[g]),
      .hit          (cell_hit[g])
    );
  end

  // sequencer owns the handshakes, the fill count and the result register
  srl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .view    (view),
    .ctl     (ctl)
  );

endmodule

>>> sim/srl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_checker
// watches the command and result channels of the sorted rank list, keeps its
// own copy of the ranked table, predicts the rank-change beats of every
// accepted command and compares them in order with the beats that come out
// ----------------------------------------------------------------------------
module srl_checker (
  input  logic                                             clk,
  input  logic                                             rst_n,
  srl_in_if                                                in_mon,
  srl_out_if                                               out_mon,
  output logic [srl_pkg::CAPACITY-1:0][srl_pkg::ID_W-1:0]  live_ids,
  output logic [srl_pkg::CAPACITY-1:0][srl_pkg::KEY_W-1:0] live_keys,
  output int                                               live_fill,
  output int                                               pending_beats,
  output int                                               mismatches,
  output int                                               beats_seen,
  output int                                               cmds_seen,
  output int                                               full_refusals,
  output int                                               bad_ranks,
  output int                                               peak_fill
);
  import srl_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [RANK_W-1:0] rank;
    logic              last;
  } rank_beat_t;

  logic [CAPACITY-1:0][ID_W-1:0]  slot_id;
  logic [CAPACITY-1:0][KEY_W-1:0] slot_key;
  int                             fill;
  rank_beat_t                     rank_beats_q[$];

  function automatic void post_beat(input logic [STAT_W-1:0] status,
                                    input logic [ID_W-1:0] id, input int rank);
    rank_beat_t b;
    b.status = status;
    b.id     = id;
    b.rank   = rank[RANK_W-1:0];
    b.last   = 1'b0;
    rank_beats_q.push_back(b);
  endfunction

  // apply one command to the table and queue the beats it should produce
  task automatic predict_rank_moves(input logic [CMD_W-1:0] cmd,
                                    input logic [ID_W-1:0] id,
                                    input logic [KEY_W-1:0] key,
                                    input logic signed [RANK_W-1:0] known);
    int         at;
    int         i;
    rank_beat_t closing;
    at = known;
    if (cmd == CMD_NONE) return;
    if (cmd == CMD_ADD) begin
      if (fill >= CAPACITY) begin
        post_beat(ST_FULL, id, RANK_NONE);
        full_refusals++;
      end else begin
        // first slot with a smaller key; equal keys stay in front
        at = fill;
        for (i = fill - 1; i >= 0; i--)
          if (key > slot_key[i]) at = i;
        for (i = fill; i > at; i--) begin
          slot_id[i]  = slot_id[i-1];
          slot_key[i] = slot_key[i-1];
          post_beat(ST_OK, slot_id[i], i);
        end
        slot_id[at]  = id;
        slot_key[at] = key;
        fill++;
        post_beat(ST_OK, id, at);
      end
    end else if (at < 0 || at >= fill || slot_id[at] != id) begin
      post_beat(ST_BAD_RANK, id, RANK_NONE);
      bad_ranks++;
    end else if (cmd == CMD_MOVE) begin
      while (at > 0 && key > slot_key[at-1]) begin
        slot_id[at]  = slot_id[at-1];
        slot_key[at] = slot_key[at-1];
        post_beat(ST_OK, slot_id[at], at);
        at--;
      end
      while (at < fill - 1 && key < slot_key[at+1]) begin
        slot_id[at]  = slot_id[at+1];
        slot_key[at] = slot_key[at+1];
        post_beat(ST_OK, slot_id[at], at);
        at++;
      end
      slot_id[at]  = id;
      slot_key[at] = key;
      post_beat(ST_OK, id, at);
    end else begin
      for (i = at; i < fill - 1; i++) begin
        slot_id[i]  = slot_id[i+1];
        slot_key[i] = slot_key[i+1];
        post_beat(ST_OK, slot_id[i], i);
      end
      fill--;
      post_beat(ST_OK, id, RANK_NONE);
    end
    closing      = rank_beats_q.pop_back();
    closing.last = 1'b1;
    rank_beats_q.push_back(closing);
  endtask

  always @(posedge clk) begin
    rank_beat_t want;
    rank_beat_t got;
    if (!rst_n) begin
      slot_id       = '0;
      slot_key      = '0;
      fill          = 0;
      rank_beats_q.delete();
      mismatches    = 0;
      beats_seen    = 0;
      cmds_seen     = 0;
      full_refusals = 0;
      bad_ranks     = 0;
      peak_fill     = 0;
    end else begin
      // result side first: a beat never belongs to a command of this same edge
      if (out_mon.valid && out_mon.ready) begin
        got.status = out_mon.status;
        got.id     = out_mon.moved_id;
        got.rank   = out_mon.new_rank;
        got.last   = out_mon.last;
        beats_seen++;
        if (rank_beats_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat status %0d id %h rank %0d last %b",
                   $time, got.status, got.id, $signed(got.rank), got.last);
        end else begin
          want = rank_beats_q.pop_front();
          if (got.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d got %0d (id %h)",
                     $time, want.status, got.status, want.id);
          end
          if (got.id !== want.id) begin
            mismatches++;
            $display("%0t: moved_id expected %h got %h", $time, want.id, got.id);
          end
          if (got.rank !== want.rank) begin
            mismatches++;
            $display("%0t: new_rank expected %0d got %0d (id %h)",
                     $time, $signed(want.rank), $signed(got.rank), want.id);
          end
          if (got.last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %b got %b (id %h)",
                     $time, want.last, got.last, want.id);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.cmd != CMD_NONE) cmds_seen++;
        predict_rank_moves(in_mon.cmd, in_mon.entry_id, in_mon.key, in_mon.known_rank);
        if (fill > peak_fill) peak_fill = fill;
      end
    end
    live_ids      <= slot_id;
    live_keys     <= slot_key;
    live_fill     <= fill;
    pending_beats <= rank_beats_q.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the sorted rank list: a short directed pass over the edge
// cases, then random command streams under varied idle and stall patterns;
// a checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_top;
  import srl_pkg::*;

  // worst run: ~350 commands, each up to 31 shifted entries plus the subject,
  // every beat open to receiver stalls, plus the long hold-off; taken many times
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;
  // the tail wait catches any beat that trails the last one we expected
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } list_cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  srl_in_if  in_if ();
  srl_out_if out_if ();

  // the checker's view of the table, used to aim moves and removes
  logic [CAPACITY-1:0][ID_W-1:0]  live_ids;
  logic [CAPACITY-1:0][KEY_W-1:0] live_keys;
  int live_fill;
  int pending_beats;
  int mismatches;
  int beats_seen;
  int cmds_seen;
  int full_refusals;
  int bad_ranks;
  int peak_fill;

  int sender_idle_pct = 0;  // only the stimulus process reads this
  int stall_pct       = 0;  // read by the receiver, written with <=
  int hold_ticket     = 0;  // bump to ask the receiver for a long hold-off
  int cycle_count     = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sorted_rank_list_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  srl_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .live_ids      (live_ids),
    .live_keys     (live_keys),
    .live_fill     (live_fill),
    .pending_beats (pending_beats),
    .mismatches    (mismatches),
    .beats_seen    (beats_seen),
    .cmds_seen     (cmds_seen),
    .full_refusals (full_refusals),
    .bad_ranks     (bad_ranks),
    .peak_fill     (peak_fill)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: no finish after %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result receiver: random stalls, or a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // offer one command beat and hold it until accepted; valid then drops so
  // the next command can be aimed at the updated table (the block keeps in
  // ready low through its plan state anyway)
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                       input logic [KEY_W-1:0] key, input logic [RANK_W-1:0] rank);
    if ($urandom_range(0, 99) < sender_idle_pct)
      repeat ($urandom_range(1, 6)) @(posedge clk);
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.entry_id   <= id;
    in_if.key        <= key;
    in_if.known_rank <= rank;
    do @(posedge clk); while (!in_if.ready);
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender pause until every predicted beat has come back
  task automatic wait_drained();
    while (pending_beats != 0) @(posedge clk);
  endtask

  // mostly well-formed commands aimed at live entries, steering the fill
  // level toward target_fill; the rest is stale ranks, wrong ids and
  // the unused command code
  function automatic list_cmd_t pick_cmd(input int target_fill);
    list_cmd_t c;
    int        roll;
    int        r;
    c.id   = ID_W'($urandom);
    c.rank = RANK_W'($urandom);
    case ($urandom_range(0, 9))
      0:       c.key = '0;
      1:       c.key = '1;
      2, 3:    c.key = KEY_W'($urandom_range(0, 7));  // narrow range, many ties
      4:       c.key = (live_fill > 0) ? live_keys[$urandom_range(0, live_fill - 1)]
                                       : KEY_W'($urandom);
      default: c.key = KEY_W'($urandom);
    endcase
    roll = $urandom_range(0, 99);
    r    = (live_fill > 0) ? $urandom_range(0, live_fill - 1) : 0;
    if (roll < 4) begin
      c.cmd = CMD_NONE;
    end else if (roll < 12) begin
      c.cmd = roll[0] ? CMD_MOVE : CMD_REMOVE;
      case ($urandom_range(0, 3))
        0: c.rank = RANK_NONE;
        1: c.rank = (live_fill < CAPACITY) ? RANK_W'($urandom_range(live_fill, CAPACITY - 1))
                                           : RANK_NONE;
        2: begin
          // right rank, wrong owner
          c.rank = RANK_W'(r);
          c.id   = live_ids[r] ^ ID_W'($urandom_range(1, 16'hFFFF));
        end
        default: ;  // fully random rank and id
      endcase
    end else begin
      if (live_fill == 0 || (live_fill < target_fill ? roll < 70 : roll < 30))
        c.cmd = CMD_ADD;
      else if (roll < (live_fill < target_fill ? 85 : 62))
        c.cmd = CMD_MOVE;
      else
        c.cmd = CMD_REMOVE;
      if (c.cmd != CMD_ADD) begin
        c.rank = RANK_W'(r);
        c.id   = live_ids[r];
      end
    end
    return c;
  endfunction

  task automatic run_phase(input int cmd_count, input int target_fill,
                           input int idle, input int stall);
    list_cmd_t c;
    int        done;
    done            = 0;
    sender_idle_pct = idle;
    stall_pct      <= stall;
    while (done < cmd_count) begin
      c = pick_cmd(target_fill);
      issue(c.cmd, c.id, c.key, c.rank);
      // ignored commands do not count toward the phase
      if (c.cmd != CMD_NONE) done++;
    end
    wait_drained();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.cmd        <= CMD_NONE;
    in_if.entry_id   <= '0;
    in_if.key        <= '0;
    in_if.known_rank <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: edge keys, ties, every command, bad-rank errors ----
    issue(CMD_REMOVE, 16'h0001, '0, '0);                 // remove from an empty table
    issue(CMD_ADD, 16'h00A0, 32'h8000_0000, RANK_W'($urandom));
    issue(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, RANK_NONE);   // largest key goes in front
    issue(CMD_ADD, 16'h0000, 32'h0000_0000, '0);          // smallest key at the back
    issue(CMD_ADD, 16'h5A5A, 32'h8000_0000, '0);          // tie lands behind the equal key
    issue(CMD_MOVE, live_ids[1], 32'h1234_5678, RANK_NONE);   // negative rank
    issue(CMD_MOVE, live_ids[0], 32'h1234_5678, RANK_W'(CAPACITY - 1)); // past the fill
    issue(CMD_MOVE, live_ids[1] ^ 16'h8001, live_keys[1], RANK_W'(1));  // wrong owner
    issue(CMD_MOVE, live_ids[1], live_keys[1], RANK_W'(1));    // order holds, subject alone
    issue(CMD_MOVE, live_ids[3], 32'hFFFF_FFFF, RANK_W'(3));   // bubble toward the front
    issue(CMD_MOVE, live_ids[0], 32'h0000_0000, '0);           // bubble to the back
    issue(CMD_MOVE, live_ids[2], 32'h8000_0001, RANK_W'(2));   // one step up
    issue(CMD_NONE, 16'h1234, KEY_W'($urandom), '0);           // dropped, no beats
    issue(CMD_REMOVE, live_ids[live_fill-1], '0, RANK_W'(live_fill - 1)); // tail, no shift
    issue(CMD_REMOVE, live_ids[0], '0, '0);                    // head, everything shifts
    issue(CMD_REMOVE, 16'h0000, '0, 6'b10_0000);               // most negative rank
    issue(CMD_ADD, 16'h7FFF, 32'h7FFF_FFFF, '0);
    issue(CMD_ADD, 16'h8000, 32'h0000_0001, '0);
    issue(CMD_MOVE, live_ids[live_fill-1], 32'hFFFF_FFFF, RANK_W'(live_fill - 1));
    issue(CMD_REMOVE, live_ids[1], '0, RANK_W'(1));
    wait_drained();

    // ---- random phases ----
    run_phase(80, CAPACITY, 0, 0);    // no idling; fill up and knock on a full table
    run_phase(70, 4, 46, 0);          // sender gaps while the table drains
    run_phase(70, 20, 0, 46);         // receiver stalls around a mid fill
    run_phase(70, CAPACITY, 33, 33);  // both sides idle, back toward full

    // long receiver hold-off while commands keep coming: the output register
    // fills and the block must hold its input
    hold_ticket <= hold_ticket + 1;
    run_phase(40, 12, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_beats != 0)
      $display("%0t: %0d predicted beats never arrived", $time, pending_beats);
    $display("run covered %0d commands and %0d result beats, %0d full-table refusals,",
             cmds_seen, beats_seen, full_refusals);
    $display("%0d bad-rank errors, fill up to %0d of %0d, with idle, stall and hold-off phases",
             bad_ranks, peak_fill, CAPACITY);
    if (mismatches == 0 && pending_beats == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
